// ===== rtl/tacc_pkg.sv =====
// ----------------------------------------------------------------------------
// tacc_pkg
// Shared types and constants of the top-1/top-5 accuracy counter.
// ----------------------------------------------------------------------------
package tacc_pkg;

  localparam int TOPK              = 5;
  localparam int VAL_W             = 16;
  localparam int CLASS_OUT_W       = 10;
  localparam int COUNT_OUT_W       = 24;
  localparam int NCLS_W            = 11;
  localparam int MAX_CLASSES_DEF   = 1024;
  localparam int COUNT_BITS_DEF    = 24;
  localparam logic [NCLS_W-1:0] NUM_CLASSES_RESET = NCLS_W'(10);

  typedef struct packed {
    logic step;
    logic start;
  } tacc_chain_ctl_t;

endpackage

// ===== rtl/tacc_slot_cell.sv =====
// ----------------------------------------------------------------------------
// tacc_slot_cell
// One slot of the ascending top-k list; takes its upper neighbor's entry when
// a new score passes both.
// ----------------------------------------------------------------------------
module tacc_slot_cell #(
  parameter int CLS_W = 10
) (
  input  logic                                clk,
  input  tacc_pkg::tacc_chain_ctl_t           ctl,
  input  logic signed [tacc_pkg::VAL_W-1:0]   score,
  input  logic [CLS_W-1:0]                    pos,
  input  logic                                up_gt,
  input  logic signed [tacc_pkg::VAL_W-1:0]   up_value,
  input  logic [CLS_W-1:0]                    up_class,
  output logic                                gt,
  output logic signed [tacc_pkg::VAL_W-1:0]   cur_value,
  output logic [CLS_W-1:0]                    cur_class,
  output logic [CLS_W-1:0]                    class_next
);
  import tacc_pkg::*;

  logic signed [VAL_W-1:0] slot_value;
  logic [CLS_W-1:0]        slot_class;
  logic signed [VAL_W-1:0] value_next;

  // slots read as zero at sample start
  assign cur_value = ctl.start ? '0 : slot_value;
  assign cur_class = ctl.start ? '0 : slot_class;
  assign gt        = score > cur_value;

  always_comb begin
    if (gt && up_gt) begin
      value_next = up_value;
      class_next = up_class;
    end else if (gt) begin
      value_next = score;
      class_next = pos;
    end else begin
      value_next = cur_value;
      class_next = cur_class;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      slot_value <= value_next;
      slot_class <= class_next;
    end
  end

endmodule

// ===== rtl/tacc_topk_chain.sv =====
// ----------------------------------------------------------------------------
// tacc_topk_chain
// Row of top-k slot cells plus the top-5 membership check.
// ----------------------------------------------------------------------------
module tacc_topk_chain #(
  parameter int CLS_W = 10
) (
  input  logic                                clk,
  input  tacc_pkg::tacc_chain_ctl_t           ctl,
  input  logic signed [tacc_pkg::VAL_W-1:0]   score,
  input  logic [CLS_W-1:0]                    pos,
  input  logic [CLS_W-1:0]                    label_class_next,
  output logic                                hit5
);
  import tacc_pkg::*;

  logic                    gt     [TOPK+1];
  logic signed [VAL_W-1:0] value  [TOPK+1];
  logic [CLS_W-1:0]        cls    [TOPK+1];
  logic [CLS_W-1:0]        cls_nx [TOPK];

  assign gt[TOPK]    = 1'b0;
  assign value[TOPK] = '0;
  assign cls[TOPK]   = '0;

  for (genvar i = 0; i < TOPK; i++) begin : g_cell
    tacc_slot_cell #(.CLS_W(CLS_W)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .score      (score),
      .pos        (pos),
      .up_gt      (gt[i+1]),
      .up_value   (value[i+1]),
      .up_class   (cls[i+1]),
      .gt         (gt[i]),
      .cur_value  (value[i]),
      .cur_class  (cls[i]),
      .class_next (cls_nx[i])
    );
  end

  always_comb begin
    hit5 = 1'b0;
    for (int i = 0; i < TOPK; i++) begin
      if (cls_nx[i] == label_class_next) hit5 = 1'b1;
    end
  end

endmodule

// ===== rtl/top1_top5_accuracy_counter.sv =====
// ----------------------------------------------------------------------------
// top1_top5_accuracy_counter
// Streams class elements of a sample, tracks score and label argmax and a
// five-slot top list, and reports hits and saturating counts per sample.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------------
//   in      | in_valid/in_stall  | score, label_value, clear_counts
//   out     | out_valid/out_stall| top1_hit, top5_hit, predicted_class,
//           |                    | true_class, top1_count, top5_count,
//           |                    | sample_count
//   cfg     | cfg_write          | cfg_data (num_classes)
//
// One request per cycle while in_stall is low; the result of a sample appears
// in the cycle after its last element is taken, from a single output register.
// in_stall rises only when the next element closes a sample and the output
// register holds an untaken result under out_stall.
// rst clears the element position, the counts and the output valid.
// ----------------------------------------------------------------------------
module top1_top5_accuracy_counter #(
  parameter int MAX_CLASSES = tacc_pkg::MAX_CLASSES_DEF,
  parameter int COUNT_BITS  = tacc_pkg::COUNT_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [tacc_pkg::NCLS_W-1:0]             cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [tacc_pkg::VAL_W-1:0]       score,
  input  logic signed [tacc_pkg::VAL_W-1:0]       label_value,
  input  logic                                    clear_counts,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    top1_hit,
  output logic                                    top5_hit,
  output logic [tacc_pkg::CLASS_OUT_W-1:0]        predicted_class,
  output logic [tacc_pkg::CLASS_OUT_W-1:0]        true_class,
  output logic [tacc_pkg::COUNT_OUT_W-1:0]        top1_count,
  output logic [tacc_pkg::COUNT_OUT_W-1:0]        top5_count,
  output logic [tacc_pkg::COUNT_OUT_W-1:0]        sample_count
);
  import tacc_pkg::*;

  localparam int CLS_W  = $clog2(MAX_CLASSES);
  localparam int CNT_NW = $clog2(MAX_CLASSES + 1);
  localparam int NW     = (CNT_NW > NCLS_W) ? CNT_NW : NCLS_W;
  localparam logic [NW-1:0]         N_MIN   = NW'(2);
  localparam logic [NW-1:0]         N_MAX   = NW'(MAX_CLASSES);
  localparam logic [COUNT_BITS-1:0] CNT_TOP = '1;

  logic [NCLS_W-1:0]       num_classes;
  logic [CLS_W-1:0]        element_counter;
  logic signed [VAL_W-1:0] best_score;
  logic [CLS_W-1:0]        best_class;
  logic signed [VAL_W-1:0] label_best_value;
  logic [CLS_W-1:0]        label_best_class;
  logic [COUNT_BITS-1:0]   top1_hits;
  logic [COUNT_BITS-1:0]   top5_hits;
  logic [COUNT_BITS-1:0]   samples_done;

  logic [NW-1:0]           n_raw;
  logic [NW-1:0]           n_eff;
  logic                    last;
  logic                    accept;
  logic                    start;
  tacc_chain_ctl_t         chain_ctl;

  logic signed [VAL_W-1:0] best_score_next;
  logic [CLS_W-1:0]        best_class_next;
  logic signed [VAL_W-1:0] label_best_value_next;
  logic [CLS_W-1:0]        label_best_class_next;
  logic                    hit1;
  logic                    hit5;
  logic [COUNT_BITS-1:0]   top1_base;
  logic [COUNT_BITS-1:0]   top5_base;
  logic [COUNT_BITS-1:0]   samples_base;
  logic [COUNT_BITS-1:0]   top1_hits_next;
  logic [COUNT_BITS-1:0]   top5_hits_next;
  logic [COUNT_BITS-1:0]   samples_done_next;
  logic [31:0]             top1_wide;
  logic [31:0]             top5_wide;
  logic [31:0]             samples_wide;
  logic [31:0]             pred_wide;
  logic [31:0]             true_wide;

  always_comb begin
    n_raw = NW'(num_classes);
    if (n_raw < N_MIN) begin
      n_eff = N_MIN;
    end else if (n_raw > N_MAX) begin
      n_eff = N_MAX;
    end else begin
      n_eff = n_raw;
    end
  end

  assign last     = (NW'(element_counter) + NW'(1)) >= n_eff;
  assign in_stall = out_valid && out_stall && last;
  assign accept   = in_valid && !in_stall;
  assign start    = (element_counter == '0);

  assign chain_ctl.step  = accept;
  assign chain_ctl.start = start;

  always_comb begin
    best_score_next       = best_score;
    best_class_next       = best_class;
    label_best_value_next = label_best_value;
    label_best_class_next = label_best_class;
    if (start) begin
      best_score_next       = score;
      best_class_next       = '0;
      label_best_value_next = label_value;
      label_best_class_next = '0;
    end else begin
      if (score > best_score) begin
        best_score_next = score;
        best_class_next = element_counter;
      end
      if (label_value > label_best_value) begin
        label_best_value_next = label_value;
        label_best_class_next = element_counter;
      end
    end
  end

  tacc_topk_chain #(.CLS_W(CLS_W)) u_chain (
    .clk              (clk),
    .ctl              (chain_ctl),
    .score            (score),
    .pos              (element_counter),
    .label_class_next (label_best_class_next),
    .hit5             (hit5)
  );

  assign hit1 = (best_class_next == label_best_class_next);

  always_comb begin
    top1_base    = clear_counts ? '0 : top1_hits;
    top5_base    = clear_counts ? '0 : top5_hits;
    samples_base = clear_counts ? '0 : samples_done;
    top1_hits_next    = top1_base;
    top5_hits_next    = top5_base;
    samples_done_next = samples_base;
    if (last) begin
      if (hit1 && top1_base != CNT_TOP) top1_hits_next = top1_base + COUNT_BITS'(1);
      if (hit5 && top5_base != CNT_TOP) top5_hits_next = top5_base + COUNT_BITS'(1);
      if (samples_base != CNT_TOP) samples_done_next = samples_base + COUNT_BITS'(1);
    end
  end

  assign top1_wide    = 32'(top1_hits_next);
  assign top5_wide    = 32'(top5_hits_next);
  assign samples_wide = 32'(samples_done_next);
  assign pred_wide    = 32'(best_class_next);
  assign true_wide    = 32'(label_best_class_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_classes     <= NUM_CLASSES_RESET;
      element_counter <= '0;
      top1_hits       <= '0;
      top5_hits       <= '0;
      samples_done    <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) num_classes <= cfg_data;
      if (accept) begin
        element_counter <= last ? '0 : element_counter + CLS_W'(1);
        top1_hits       <= top1_hits_next;
        top5_hits       <= top5_hits_next;
        samples_done    <= samples_done_next;
      end
      if (accept && last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      best_score       <= best_score_next;
      best_class       <= best_class_next;
      label_best_value <= label_best_value_next;
      label_best_class <= label_best_class_next;
    end
    if (accept && last) begin
      top1_hit        <= hit1;
      top5_hit        <= hit5;
      predicted_class <= pred_wide[CLASS_OUT_W-1:0];
      true_class      <= true_wide[CLASS_OUT_W-1:0];
      top1_count      <= top1_wide[COUNT_OUT_W-1:0];
      top5_count      <= top5_wide[COUNT_OUT_W-1:0];
      sample_count    <= samples_wide[COUNT_OUT_W-1:0];
    end
  end

endmodule

// ===== tb/top1_top5_accuracy_counter_test.sv =====
// ----------------------------------------------------------------------------
// top1_top5_accuracy_counter_test
// Streams class elements into the accuracy counter and checks every sample
// report against a cycle-free predictor of argmax, top-5 list and counts.
// Covers class-count clamping, mid-sample count changes, score ties, the
// zero-seeded top list, count clears and output back-pressure.
// ----------------------------------------------------------------------------
module top1_top5_accuracy_counter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tacc_pkg::*;

  typedef struct packed {
    logic                   top1;
    logic                   top5;
    logic [CLASS_OUT_W-1:0] pred_cls;
    logic [CLASS_OUT_W-1:0] true_cls;
    logic [COUNT_OUT_W-1:0] top1_cnt;
    logic [COUNT_OUT_W-1:0] top5_cnt;
    logic [COUNT_OUT_W-1:0] samples;
  } sample_report_t;

  class accuracy_scoreboard;
    logic [NCLS_W-1:0]          ncls_q = NUM_CLASSES_RESET;
    logic [CLASS_OUT_W-1:0]     elem_pos = '0;
    logic signed [VAL_W-1:0]    best_score_q = '0;
    logic [CLASS_OUT_W-1:0]     best_cls = '0;
    logic signed [VAL_W-1:0]    best_label_q = '0;
    logic [CLASS_OUT_W-1:0]     label_cls = '0;
    logic signed [VAL_W-1:0]    slot_val [TOPK];
    logic [CLASS_OUT_W-1:0]     slot_cls [TOPK];
    logic [COUNT_OUT_W-1:0]     hits1 = '0;
    logic [COUNT_OUT_W-1:0]     hits5 = '0;
    logic [COUNT_OUT_W-1:0]     done_cnt = '0;
    sample_report_t             reports [$];
    int                         errors = 0;

    function void set_classes(logic [NCLS_W-1:0] v);
      ncls_q = v;
    endfunction

    function void note_request(logic signed [VAL_W-1:0] s, logic signed [VAL_W-1:0] l,
                               logic clr);
      int n;
      logic signed [VAL_W-1:0] tv;
      logic [CLASS_OUT_W-1:0] tc;
      sample_report_t r;
      n = ncls_q;
      if (n < 2) n = 2;
      if (n > MAX_CLASSES_DEF) n = MAX_CLASSES_DEF;
      if (clr) begin
        hits1 = '0;
        hits5 = '0;
        done_cnt = '0;
      end
      if (elem_pos == 0) begin
        best_score_q = s;
        best_cls = '0;
        best_label_q = l;
        label_cls = '0;
        for (int i = 0; i < TOPK; i++) begin
          slot_val[i] = '0;
          slot_cls[i] = '0;
        end
      end else begin
        if (s > best_score_q) begin
          best_score_q = s;
          best_cls = elem_pos;
        end
        if (l > best_label_q) begin
          best_label_q = l;
          label_cls = elem_pos;
        end
      end
      if (s > slot_val[0]) begin
        slot_val[0] = s;
        slot_cls[0] = elem_pos;
        for (int i = 0; i < TOPK - 1; i++) begin
          if (slot_val[i] > slot_val[i+1]) begin
            tv = slot_val[i];
            tc = slot_cls[i];
            slot_val[i] = slot_val[i+1];
            slot_cls[i] = slot_cls[i+1];
            slot_val[i+1] = tv;
            slot_cls[i+1] = tc;
          end else begin
            break;
          end
        end
      end
      if (int'(elem_pos) + 1 < n) begin
        elem_pos++;
        return;
      end
      elem_pos = '0;
      r.top1 = (best_cls == label_cls);
      r.top5 = 1'b0;
      for (int i = 0; i < TOPK; i++)
        if (slot_cls[i] == label_cls) r.top5 = 1'b1;
      if (r.top1 && hits1 != '1) hits1++;
      if (r.top5 && hits5 != '1) hits5++;
      if (done_cnt != '1) done_cnt++;
      r.pred_cls = best_cls;
      r.true_cls = label_cls;
      r.top1_cnt = hits1;
      r.top5_cnt = hits5;
      r.samples = done_cnt;
      reports.push_back(r);
    endfunction

    function void check_result(sample_report_t got);
      sample_report_t want;
      bit bad;
      if (reports.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: unexpected report %p", $realtime, got);
        return;
      end
      want = reports.pop_front();
      bad = (got.top1 !== want.top1) || (got.top5 !== want.top5) ||
            (got.pred_cls !== want.pred_cls) || (got.true_cls !== want.true_cls) ||
            (got.top1_cnt !== want.top1_cnt) || (got.top5_cnt !== want.top5_cnt) ||
            (got.samples !== want.samples);
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display({"%0t: mismatch top1 %0b/%0b top5 %0b/%0b pred %0d/%0d true %0d/%0d",
                    " c1 %0d/%0d c5 %0d/%0d n %0d/%0d (exp/act)"}, $realtime,
                   want.top1, got.top1, want.top5, got.top5, want.pred_cls, got.pred_cls,
                   want.true_cls, got.true_cls, want.top1_cnt, got.top1_cnt,
                   want.top5_cnt, got.top5_cnt, want.samples, got.samples);
      end
    endfunction

    function void flush_leftover();
      if (reports.size() != 0) begin
        errors += reports.size();
        if (errors <= 10) $display("%0d reports never arrived", reports.size());
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [NCLS_W-1:0]             cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [VAL_W-1:0]       score = '0;
  logic signed [VAL_W-1:0]       label_value = '0;
  logic                          clear_counts = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          top1_hit;
  logic                          top5_hit;
  logic [CLASS_OUT_W-1:0]        predicted_class;
  logic [CLASS_OUT_W-1:0]        true_class;
  logic [COUNT_OUT_W-1:0]        top1_count;
  logic [COUNT_OUT_W-1:0]        top5_count;
  logic [COUNT_OUT_W-1:0]        sample_count;

  accuracy_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int sample_len = 10;
  int elem_idx = 0;
  int hot_cls = 0;

  top1_top5_accuracy_counter dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .score           (score),
    .label_value     (label_value),
    .clear_counts    (clear_counts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .top1_hit        (top1_hit),
    .top5_hit        (top5_hit),
    .predicted_class (predicted_class),
    .true_class      (true_class),
    .top1_count      (top1_count),
    .top5_count      (top5_count),
    .sample_count    (sample_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int hold_left;
    int holds_done;
    hold_left = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_done != hold_requests) begin
        holds_done = hold_requests;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{top1_hit, top5_hit, predicted_class, true_class,
                        top1_count, top5_count, sample_count});
  end

  task automatic send_element(input logic signed [VAL_W-1:0] s,
                              input logic signed [VAL_W-1:0] l, input logic c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    score <= s;
    label_value <= l;
    clear_counts <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(s, l, c);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_classes(input int v);
    cfg_write <= 1'b1;
    cfg_data <= NCLS_W'(v);
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_classes(NCLS_W'(v));
    sample_len = (v < 2) ? 2 : (v > MAX_CLASSES_DEF) ? MAX_CLASSES_DEF : v;
    if (elem_idx >= sample_len) elem_idx = 0;
  endtask

  // mostly one-hot labels; scores mix full range, near ties and extremes
  task automatic random_element(input int clr_pct);
    logic signed [VAL_W-1:0] s;
    logic signed [VAL_W-1:0] l;
    if (elem_idx == 0) hot_cls = $urandom_range(sample_len - 1);
    if ($urandom_range(99) < 85)
      l = (elem_idx == hot_cls) ? 16'sh0100 : 16'sh0000;
    else
      l = VAL_W'($urandom);
    case ($urandom_range(9))
      6, 7:    s = VAL_W'(int'($urandom_range(8)) - 4);
      8:       s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      9:       s = (elem_idx == hot_cls) ? VAL_W'(32512 + $urandom_range(255)) : -16'sd3;
      default: s = VAL_W'($urandom);
    endcase
    send_element(s, l, $urandom_range(99) < clr_pct);
    elem_idx = (elem_idx + 1 >= sample_len) ? 0 : elem_idx + 1;
  endtask

  task automatic random_phase(input int idle_pct, input int stall_pct, input int items);
    int sent;
    int chunk;
    int pick;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      drain();
      pick = $urandom_range(19);
      write_classes(pick == 0 ? 0 : pick == 1 ? 1 : $urandom_range(2, 12));
      chunk = $urandom_range(20, 70);
      repeat (chunk) random_element(3);
      sent += chunk;
    end
  endtask

  initial begin
    logic signed [VAL_W-1:0] first_scores [10];
    first_scores = '{16'sh8000, 16'sd100, 16'sd32767, 16'sd32767, -16'sd5,
                     16'sd0, 16'sd200, 16'sd300, 16'sd32767, 16'sd1};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset class count, tied maxima, extreme values, clear on first element
    for (int i = 0; i < 10; i++)
      send_element(first_scores[i], i == 2 ? 16'sh0100 : i == 9 ? 16'sh8000 : 16'sh0000,
                   i == 0);
    drain();
    // all scores negative: class 0 sits in the zero-seeded top list
    write_classes(5);
    for (int i = 0; i < 5; i++)
      send_element(i == 2 ? 16'sh8000 : VAL_W'(-1 - i), i == 0 ? 16'sh0100 : 16'sh0000, 0);
    for (int i = 0; i < 5; i++)
      send_element(-16'sd1, i == 3 ? 16'sh7FFF : 16'sh0000, 0);
    drain();
    // counts below two clamp to two; clear on the last element
    write_classes(0);
    send_element(16'sd7, 16'sh7FFF, 0);
    send_element(16'sd7, 16'sh7FFF, 1);
    drain();
    write_classes(1);
    send_element(16'sh8000, 16'sh8000, 0);
    send_element(16'sh7FFF, 16'sh8000, 0);
    drain();
    // count lowered mid-sample: next element closes it
    write_classes(6);
    for (int i = 0; i < 3; i++) send_element(VAL_W'(i * 50), VAL_W'(i), 0);
    drain();
    write_classes(2);
    send_element(16'sd10, 16'sd0, 0);
    drain();

    // long output hold-off while elements keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_classes(2);
    hold_requests++;
    repeat (40) random_element(3);

    random_phase(8, 61, 90);
    random_phase(61, 8, 90);
    random_phase(0, 0, 90);

    // wide sample held open at the maximum and clamped from above,
    // then closed early by a small count
    drain();
    write_classes(MAX_CLASSES_DEF);
    repeat (60) random_element(0);
    drain();
    write_classes(2047);
    repeat (60) random_element(0);
    drain();
    write_classes(3);
    repeat (30) random_element(3);

    drain();
    repeat (8) @(posedge clk);
    sb.flush_leftover();
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #3ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
